// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/imh_pkg.sv =====
// Constants, codes and types of the indexed min-heap.
package imh_pkg;

   localparam int CAPACITY = 1024;
   localparam int ID_COUNT = 1024;
   localparam int KEY_W    = 32;
   localparam int ID_W     = 10;
   localparam int OP_W     = 3;
   localparam int ST_W     = 3;
   localparam int SLOT_W   = $clog2(CAPACITY + 1);
   localparam int MAP_AW   = $clog2(ID_COUNT);

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
   localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
   localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

   // one heap slot
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } heap_entry_type;

endpackage

// ===== hw/rtl/imh_ram.sv =====
// Generic simple dual-port RAM with registered read.
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/indexed_min_heap_top.sv =====
// Indexed binary min-heap priority queue: sequencer over heap and map RAMs.
//
//  channel | ports                                     | dir
//  --------+-------------------------------------------+-----
//  req     | req_valid req_ready req_opcode            | in
//          | req_item_id req_item_key                  |
//  rsp     | rsp_valid rsp_ready rsp_status            | out
//          | rsp_top_valid rsp_top_id rsp_top_key      |
//          | rsp_entry_count                           |
//
// Requests are served one at a time. An error or no-op goes from S_LOOK straight to S_FIN;
// pop or remove of the last entry passes S_REM only; insert climbs through S_UP and S_UP_RD
// per level; update sifts down through S_DN, S_DN_L and S_DN_R and climbs only if it did not
// move down; remove and pop first fill the gap. The single read port of the heap RAM sets the cost.
// Reset and clear sweep all ID_COUNT (1024) map entries; a clear then ends through S_FIN.
// The response waits in its output register while the next request is taken; only S_OUT stalls.
`include "assert_macros.svh"

module indexed_min_heap_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [imh_pkg::OP_W-1:0]     req_opcode,
   input  logic [imh_pkg::ID_W-1:0]     req_item_id,
   input  logic [imh_pkg::KEY_W-1:0]    req_item_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [imh_pkg::ST_W-1:0]     rsp_status,
   output logic                         rsp_top_valid,
   output logic [imh_pkg::ID_W-1:0]     rsp_top_id,
   output logic [imh_pkg::KEY_W-1:0]    rsp_top_key,
   output logic [imh_pkg::SLOT_W-1:0]   rsp_entry_count
);
   import imh_pkg::*;

   localparam int ENTRY_W = ID_W + KEY_W;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_LOOK, S_REM, S_REM_RD, S_DN, S_DN_L, S_DN_R,
      S_UP, S_UP_RD, S_PLACE, S_FIN, S_TOP, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0]     child_ff, child_in;
   heap_entry_type        cur_ff, cur_in;
   heap_entry_type        best_ff, best_in;
   logic                  moved_ff, moved_in;
   logic [ST_W-1:0]       status_ff, status_in;
   logic [MAP_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  pend_ff, pend_in;
   logic [ID_W-1:0]       top_id_ff, top_id_in;
   logic [KEY_W-1:0]      top_key_ff, top_key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                  rsp_top_valid_ff, rsp_top_valid_in;
   logic [ID_W-1:0]       rsp_top_id_ff, rsp_top_id_in;
   logic [KEY_W-1:0]      rsp_top_key_ff, rsp_top_key_in;
   logic [SLOT_W-1:0]     rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                  heap_we;
   logic [SLOT_W-1:0]     heap_waddr, heap_raddr;
   heap_entry_type        heap_wdata, heap_rd;
   logic [ENTRY_W-1:0]    heap_rdata;
   logic                  map_we;
   logic [MAP_AW-1:0]     map_waddr, map_raddr;
   logic [SLOT_W-1:0]     map_wdata, map_rd;

   // decode helpers
   logic                  id_ok;
   logic [SLOT_W-1:0]     pos_l;
   logic [SLOT_W:0]       child_w;
   heap_entry_type        cand;
   logic [SLOT_W-1:0]     cand_pos;

   imh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY + 1)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   imh_ram #(.WIDTH(SLOT_W), .DEPTH(ID_COUNT)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rd)
   );

   assign heap_rd = heap_entry_type'(heap_rdata);
   assign id_ok   = (32'(id_ff) < ID_COUNT);
   assign pos_l   = id_ok ? map_rd : '0;
   assign child_w = {pos_ff, 1'b0};

   // smaller child; right wins only on strictly smaller key
   always_comb begin
      cand     = heap_rd;
      cand_pos = child_ff;
      if (state_ff == S_DN_R) begin
         if (heap_rd.key < best_ff.key) begin
            cand     = heap_rd;
            cand_pos = {child_ff[SLOT_W-1:1], 1'b1};
         end else begin
            cand     = best_ff;
            cand_pos = child_ff;
         end
      end
   end

   // sequencer next state and RAM control
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      key_in           = key_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      child_in         = child_ff;
      cur_in           = cur_ff;
      best_in          = best_ff;
      moved_in         = moved_ff;
      status_in        = status_ff;
      clr_cnt_in       = clr_cnt_ff;
      pend_in          = pend_ff;
      top_id_in        = top_id_ff;
      top_key_in       = top_key_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_top_id_in    = rsp_top_id_ff;
      rsp_top_key_in   = rsp_top_key_ff;
      rsp_count_in     = rsp_count_ff;
      heap_we          = 1'b0;
      heap_waddr       = pos_ff;
      heap_wdata       = cur_ff;
      heap_raddr       = SLOT_W'(1);
      map_we           = 1'b0;
      map_waddr        = cur_ff.id[MAP_AW-1:0];
      map_wdata        = pos_ff;
      map_raddr        = id_ff[MAP_AW-1:0];
      req_ready        = 1'b0;

      case (state_ff)
         // map sweep after reset or clear
         S_CLR: begin
            map_we     = 1'b1;
            map_waddr  = clr_cnt_ff;
            map_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + MAP_AW'(1);
            if (clr_cnt_ff == MAP_AW'(ID_COUNT - 1)) begin
               clr_cnt_in = '0;
               pend_in    = 1'b0;
               state_in   = pend_ff ? S_FIN : S_IDLE;
            end
         end
         // take request, look up id and top slot
         S_IDLE: begin
            req_ready = 1'b1;
            map_raddr = req_item_id[MAP_AW-1:0];
            if (req_valid) begin
               op_in    = req_opcode;
               id_in    = req_item_id;
               key_in   = req_item_key;
               state_in = S_LOOK;
            end
         end
         // check and dispatch
         S_LOOK: begin
            status_in = ST_OK;
            moved_in  = 1'b0;
            state_in  = S_FIN;
            case (op_ff)
               OP_INSERT: begin
                  if (!id_ok) begin
                     status_in = ST_ABSENT;
                  end else if (pos_l != '0) begin
                     status_in = ST_PRESENT;
                  end else if (count_ff >= SLOT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + SLOT_W'(1);
                     pos_in   = count_ff + SLOT_W'(1);
                     cur_in   = '{id: id_ff, key: key_ff};
                     state_in = S_UP;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     map_we    = 1'b1;
                     map_waddr = heap_rd.id[MAP_AW-1:0];
                     map_wdata = '0;
                     pos_in    = SLOT_W'(1);
                     state_in  = S_REM;
                  end
               end
               OP_UPDATE: begin
                  if (pos_l == '0 || pos_l > count_ff) begin
                     status_in = ST_ABSENT;
                  end else begin
                     cur_in   = '{id: id_ff, key: key_ff};
                     pos_in   = pos_l;
                     state_in = S_DN;
                  end
               end
               OP_REMOVE: begin
                  if (pos_l == '0 || pos_l > count_ff) begin
                     status_in = ST_ABSENT;
                  end else begin
                     map_we    = 1'b1;
                     map_waddr = id_ff[MAP_AW-1:0];
                     map_wdata = '0;
                     pos_in    = pos_l;
                     state_in  = S_REM;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  pend_in  = 1'b1;
                  state_in = S_CLR;
               end
               default: begin
               end
            endcase
         end
         // last entry fills the gap
         S_REM: begin
            if (pos_ff == count_ff) begin
               count_in = count_ff - SLOT_W'(1);
               state_in = S_FIN;
            end else begin
               heap_raddr = count_ff;
               state_in   = S_REM_RD;
            end
         end
         S_REM_RD: begin
            cur_in   = heap_rd;
            count_in = count_ff - SLOT_W'(1);
            state_in = S_DN;
         end
         // sift down: fetch left child
         S_DN: begin
            if (child_w > {1'b0, count_ff}) begin
               state_in = moved_ff ? S_PLACE : S_UP;
            end else begin
               heap_raddr = child_w[SLOT_W-1:0];
               child_in   = child_w[SLOT_W-1:0];
               state_in   = S_DN_L;
            end
         end
         // left child in; fetch right or compare
         S_DN_L, S_DN_R: begin
            best_in = heap_rd;
            if (state_ff == S_DN_L && child_ff != count_ff) begin
               heap_raddr = {child_ff[SLOT_W-1:1], 1'b1};
               state_in   = S_DN_R;
            end else if (cand.key < cur_ff.key) begin
               heap_we    = 1'b1;
               heap_wdata = cand;
               map_we     = 1'b1;
               map_waddr  = cand.id[MAP_AW-1:0];
               pos_in     = cand_pos;
               moved_in   = 1'b1;
               state_in   = S_DN;
            end else begin
               state_in = moved_ff ? S_PLACE : S_UP;
            end
         end
         // sift up: fetch parent
         S_UP: begin
            if (pos_ff > SLOT_W'(1)) begin
               heap_raddr = {1'b0, pos_ff[SLOT_W-1:1]};
               state_in   = S_UP_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_UP_RD: begin
            if (cur_ff.key < heap_rd.key) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rd;
               map_we     = 1'b1;
               map_waddr  = heap_rd.id[MAP_AW-1:0];
               pos_in     = {1'b0, pos_ff[SLOT_W-1:1]};
               state_in   = S_UP;
            end else begin
               state_in = S_PLACE;
            end
         end
         // final slot of the moving entry
         S_PLACE: begin
            heap_we  = 1'b1;
            map_we   = 1'b1;
            state_in = S_FIN;
         end
         // read the top slot
         S_FIN: begin
            state_in = S_TOP;
         end
         S_TOP: begin
            top_id_in  = (count_ff != '0) ? heap_rd.id : '0;
            top_key_in = (count_ff != '0) ? heap_rd.key : '0;
            state_in   = S_OUT;
         end
         // hand over to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_top_valid_in = (count_ff != '0);
               rsp_top_id_in    = top_id_ff;
               rsp_top_key_in   = top_key_ff;
               rsp_count_in     = count_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         count_ff     <= '0;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         moved_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         moved_ff     <= moved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      id_ff            <= id_in;
      key_ff           <= key_in;
      pos_ff           <= pos_in;
      child_ff         <= child_in;
      cur_ff           <= cur_in;
      best_ff          <= best_in;
      status_ff        <= status_in;
      top_id_ff        <= top_id_in;
      top_key_ff       <= top_key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_top_id_ff    <= rsp_top_id_in;
      rsp_top_key_ff   <= rsp_top_key_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_valid   = rsp_top_valid_ff;
   assign rsp_top_id      = rsp_top_id_ff;
   assign rsp_top_key     = rsp_top_key_ff;
   assign rsp_entry_count = rsp_count_ff;

   // checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= SLOT_W'(CAPACITY))
   `ASSERT_IMPLY(a_pos_in_heap, clock, reset, (state_ff == S_DN || state_ff == S_UP), (pos_ff != '0 && pos_ff <= count_ff))
   `ASSERT_IMPLY(a_empty_top, clock, reset, (rsp_valid_ff && rsp_count_ff == '0), (!rsp_top_valid_ff && rsp_top_id_ff == '0 && rsp_top_key_ff == '0))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the indexed min-heap: random and directed requests, scoreboard.
`timescale 1ns / 100ps

module tb_top;
   import imh_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [ID_W-1:0]  item_id;
      logic [KEY_W-1:0] item_key;
   } heap_req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic              top_valid;
      logic [ID_W-1:0]   top_id;
      logic [KEY_W-1:0]  top_key;
      logic [SLOT_W-1:0] entry_count;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0]  req_opcode = '0;
   logic [ID_W-1:0]  req_item_id = '0;
   logic [KEY_W-1:0] req_item_key = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ST_W-1:0]   rsp_status;
   logic              rsp_top_valid;
   logic [ID_W-1:0]   rsp_top_id;
   logic [KEY_W-1:0]  rsp_top_key;
   logic [SLOT_W-1:0] rsp_entry_count;

   indexed_min_heap_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_item_id(req_item_id), .req_item_key(req_item_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_top_valid(rsp_top_valid), .rsp_top_id(rsp_top_id),
      .rsp_top_key(rsp_top_key), .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: heap slots 1..count, id-to-slot map
   logic [ID_W-1:0]   shadow_ids [1:CAPACITY];
   logic [KEY_W-1:0]  shadow_keys[1:CAPACITY];
   int unsigned       shadow_pos [0:ID_COUNT-1];
   int unsigned       shadow_count;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  recv_hold = 1'b0;
   // request taken at the last rising edge
   logic req_taken = 1'b0;

   function automatic void shadow_place(int unsigned p, logic [ID_W-1:0] id,
                                        logic [KEY_W-1:0] k);
      shadow_ids[p]  = id;
      shadow_keys[p] = k;
      shadow_pos[id] = p;
   endfunction

   function automatic void shadow_sift_up(int unsigned p);
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] k;
      id = shadow_ids[p];
      k  = shadow_keys[p];
      while (p > 1 && k < shadow_keys[p >> 1]) begin
         shadow_place(p, shadow_ids[p >> 1], shadow_keys[p >> 1]);
         p = p >> 1;
      end
      shadow_place(p, id, k);
   endfunction

   function automatic void shadow_sift_down(int unsigned p);
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] k;
      int unsigned c;
      id = shadow_ids[p];
      k  = shadow_keys[p];
      forever begin
         c = p << 1;
         if (c > shadow_count) break;
         if (c != shadow_count && shadow_keys[c+1] < shadow_keys[c]) c++;
         if (!(shadow_keys[c] < k)) break;
         shadow_place(p, shadow_ids[c], shadow_keys[c]);
         p = c;
      end
      shadow_place(p, id, k);
   endfunction

   // apply one request to the shadow heap and return the expected response
   function automatic heap_rsp_type heap_predict(heap_req_type r);
      heap_rsp_type o;
      int unsigned p;
      o = '0;
      o.status = ST_OK;
      p = shadow_pos[r.item_id];
      case (r.opcode)
         OP_INSERT: begin
            if (p != 0) o.status = ST_PRESENT;
            else if (shadow_count >= CAPACITY) o.status = ST_FULL;
            else begin
               shadow_count++;
               shadow_place(shadow_count, r.item_id, r.item_key);
               shadow_sift_up(shadow_count);
            end
         end
         OP_POP: begin
            if (shadow_count == 0) o.status = ST_EMPTY;
            else begin
               shadow_pos[shadow_ids[1]] = 0;
               shadow_ids[1]  = shadow_ids[shadow_count];
               shadow_keys[1] = shadow_keys[shadow_count];
               shadow_count--;
               if (shadow_count != 0) begin
                  shadow_pos[shadow_ids[1]] = 1;
                  shadow_sift_down(1);
               end
            end
         end
         OP_UPDATE: begin
            if (p == 0 || p > shadow_count) o.status = ST_ABSENT;
            else begin
               shadow_keys[p] = r.item_key;
               shadow_sift_down(p);
               shadow_sift_up(p);
            end
         end
         OP_REMOVE: begin
            if (p == 0 || p > shadow_count) o.status = ST_ABSENT;
            else begin
               shadow_pos[r.item_id] = 0;
               if (p != shadow_count) begin
                  shadow_place(p, shadow_ids[shadow_count], shadow_keys[shadow_count]);
                  shadow_count--;
                  shadow_sift_down(p);
                  shadow_sift_up(p);
               end else begin
                  shadow_count--;
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ID_COUNT; i++) shadow_pos[i] = 0;
            shadow_count = 0;
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         o.top_valid = 1'b1;
         o.top_id    = shadow_ids[1];
         o.top_key   = shadow_keys[1];
      end
      o.entry_count = shadow_count[SLOT_W-1:0];
      return o;
   endfunction

   // driver: present requests on the falling edge, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // holding current request
         end else if (pending_reqs.size() != 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            heap_req_type r;
            r = pending_reqs.pop_front();
            req_opcode   <= r.opcode;
            req_item_id  <= r.item_id;
            req_item_key <= r.item_key;
            req_valid    <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            expected_rsps.insert(expected_rsps.size(),
                                 heap_predict({req_opcode, req_item_id, req_item_key}));
         if (rsp_valid && rsp_ready) begin
            heap_rsp_type got, want;
            got = {rsp_status, rsp_top_valid, rsp_top_id, rsp_top_key, rsp_entry_count};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(3))
         0: return KEY_W'($urandom_range(15));
         1: return '1 - KEY_W'($urandom_range(3));
         default: return KEY_W'($urandom());
      endcase
   endfunction

   task automatic queue_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [KEY_W-1:0] k);
      heap_req_type r;
      r = {op, id, k};
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // random mix over ids 0..id_span; a small span makes updates and removes hit
   task automatic queue_random(int n, int id_span);
      int op_sel;
      for (int i = 0; i < n; i++) begin
         op_sel = $urandom_range(99);
         if (op_sel < 40)
            queue_req(OP_INSERT, ID_W'($urandom_range(id_span)), rand_key());
         else if (op_sel < 60)
            queue_req(OP_POP, ID_W'($urandom()), KEY_W'($urandom()));
         else if (op_sel < 78)
            queue_req(OP_UPDATE, ID_W'($urandom_range(id_span)), rand_key());
         else if (op_sel < 94)
            queue_req(OP_REMOVE, ID_W'($urandom_range(id_span)), KEY_W'($urandom()));
         else if (op_sel < 96)
            queue_req(OP_CLEAR, ID_W'($urandom()), KEY_W'($urandom()));
         else
            queue_req(OP_W'(5 + $urandom_range(2)), ID_W'($urandom()), KEY_W'($urandom()));
      end
   endtask

   initial begin
      shadow_count = 0;
      for (int i = 0; i < ID_COUNT; i++) shadow_pos[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, absent id, extremes, duplicate, ties, no-op, clear
      queue_req(OP_POP, '0, '0);
      queue_req(OP_UPDATE, 10'd5, '0);
      queue_req(OP_REMOVE, 10'd1023, '0);
      queue_req(OP_INSERT, 10'd1023, '1);
      queue_req(OP_INSERT, 10'd0, '0);
      queue_req(OP_INSERT, 10'd0, 32'd7);
      queue_req(OP_INSERT, 10'd512, 32'h8000_0000);
      queue_req(OP_INSERT, 10'd341, 32'h8000_0000);
      queue_req(OP_INSERT, 10'd682, 32'h5555_5555);
      queue_req(OP_UPDATE, 10'd0, '1);
      queue_req(OP_UPDATE, 10'd1023, 32'd0);
      queue_req(OP_REMOVE, 10'd1023, '0);
      queue_req(OP_REMOVE, 10'd0, '0);
      queue_req(3'd5, 10'd3, 32'd9);
      queue_req(3'd7, 10'd1023, '1);
      queue_req(OP_POP, '0, '0);
      queue_req(OP_CLEAR, '0, '0);
      queue_req(OP_POP, '0, '0);
      queue_req(OP_INSERT, 10'd3, 32'd1);
      queue_req(3'd6, '0, '0);
      wait_drained();

      // phase: no idling
      queue_random(110, 31);
      wait_drained();
      // phase: sender mostly idle
      send_idle_pct = 77;
      queue_random(80, 63);
      wait_drained();
      // long receiver hold-off while requests keep coming
      send_idle_pct = 0;
      recv_hold = 1'b1;
      queue_random(40, 1023);
      repeat (600) @(posedge clock);
      recv_hold = 1'b0;
      wait_drained();
      // phase: receiver stalling
      recv_stall_pct = 77;
      queue_random(100, 63);
      wait_drained();
      // phase: both idling
      send_idle_pct = 13;
      recv_stall_pct = 13;
      queue_random(100, 1023);
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule

// ===== indexed_min_heap_top.f =====
+incdir+hw/rtl
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/indexed_min_heap_top.sv
tb/sv/tb_top.sv
